/* hdl/bscff_pkg.sv */
package bscff_pkg;

    // store geometry
    localparam int MAX_BITS = 1024;
    localparam int WORD_W   = 64;
    localparam int BIT_AW   = $clog2(WORD_W);
    localparam int N_WORDS  = (MAX_BITS + WORD_W - 1) / WORD_W;
    localparam int WORD_AW  = (N_WORDS > 1) ? $clog2(N_WORDS) : 1;

    // field widths
    localparam int OP_W  = 4;
    localparam int LEN_W = 11;
    localparam int POP_W = BIT_AW + 1;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_BITS);

    typedef enum logic [OP_W-1:0] {
        OP_SET      = 4'd0,
        OP_CLR      = 4'd1,
        OP_TEST     = 4'd2,
        OP_RANGE    = 4'd3,
        OP_COUNT    = 4'd4,
        OP_EMPTY    = 4'd5,
        OP_FIND     = 4'd6,
        OP_FIND_CLR = 4'd7,
        OP_CLR_ALL  = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // result of examining one masked store word
    typedef struct packed {
        logic              any;
        logic [BIT_AW-1:0] first;
        logic [POP_W-1:0]  pop;
    } t_word_res;

endpackage

/* hdl/bscff_ram.sv */
module bscff_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/bscff_word_unit.sv */
module bscff_word_unit (
    input  logic [bscff_pkg::WORD_W-1:0]  i_data,
    input  logic [bscff_pkg::WORD_AW-1:0] i_word,
    input  logic [bscff_pkg::LEN_W-1:0]   i_lo,
    input  logic [bscff_pkg::LEN_W-1:0]   i_hi,
    output bscff_pkg::t_word_res          o_res
);

    localparam int WSEL_W = bscff_pkg::LEN_W - bscff_pkg::BIT_AW;

    logic [bscff_pkg::WORD_W-1:0] lo_mask;
    logic [bscff_pkg::WORD_W-1:0] hi_mask;
    logic [bscff_pkg::WORD_W-1:0] masked;
    logic [WSEL_W-1:0]            word_ext;

    // keep only the bits whose index lies within lo..hi
    always_comb begin
        word_ext = WSEL_W'(i_word);
        lo_mask  = '1;
        hi_mask  = '1;
        if (word_ext == i_lo[bscff_pkg::LEN_W-1:bscff_pkg::BIT_AW]) begin
            lo_mask = {bscff_pkg::WORD_W{1'b1}} << i_lo[bscff_pkg::BIT_AW-1:0];
        end
        if (word_ext == i_hi[bscff_pkg::LEN_W-1:bscff_pkg::BIT_AW]) begin
            hi_mask = {bscff_pkg::WORD_W{1'b1}} >>
                      (bscff_pkg::BIT_AW'(bscff_pkg::WORD_W - 1) -
                       i_hi[bscff_pkg::BIT_AW-1:0]);
        end
        masked = i_data & lo_mask & hi_mask;
    end

    // population count and lowest set bit
    always_comb begin
        o_res.any   = |masked;
        o_res.pop   = '0;
        o_res.first = '0;
        for (int j = 0; j < bscff_pkg::WORD_W; j++) begin
            o_res.pop = o_res.pop + bscff_pkg::POP_W'(masked[j]);
        end
        for (int j = bscff_pkg::WORD_W - 1; j >= 0; j--) begin
            if (masked[j]) begin
                o_res.first = bscff_pkg::BIT_AW'(j);
            end
        end
    end

endmodule

/* hdl/bitmap_set_clear_find_first_core.sv */
// Bitmap of 1024 positions (numbered from 1) with set, clear, test, range test,
// population count, empty check, find first set, find first set and clear, and
// clear all. The map sits in a 16 x 64-bit RAM; a small sequencer streams the
// words an operation touches through one shared word unit (mask, popcount,
// priority encode), one word per cycle. An operation reads only the 64-bit
// words it touches: one word for set, clear and test, up to all 16 for a
// full scan of count, empty or find (these stop at the first hit where they
// can). Invalid positions, unused op codes and clear all skip the scan. Clear
// all and reset take effect at once through per-word valid bits, so there is
// no clearing pass. A finished result waits in the output register while the
// next transaction is accepted. The length register may only be written while
// idle.
module bitmap_set_clear_find_first_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [bscff_pkg::LEN_W-1:0]    i_cfg_wr_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bscff_pkg::OP_W-1:0]     i_op,
    input  logic [bscff_pkg::LEN_W-1:0]    i_bit_pos,
    input  logic [bscff_pkg::LEN_W-1:0]    i_bit_pos_end,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_status,
    output logic                           o_flag,
    output logic [bscff_pkg::LEN_W-1:0]    o_position,
    output logic [bscff_pkg::LEN_W-1:0]    o_count
);

    // control state
    bscff_pkg::t_state                 r_state, n_state;
    logic                              r_out_valid, n_out_valid;
    logic                              r_dv, n_dv;
    logic                              r_issue, n_issue;
    logic [bscff_pkg::N_WORDS-1:0]     r_valid, n_valid;
    logic [bscff_pkg::LEN_W-1:0]       r_map_len;

    // operation payload
    bscff_pkg::t_op                    r_op, n_op;
    logic [bscff_pkg::LEN_W-1:0]       r_lo, n_lo;
    logic [bscff_pkg::LEN_W-1:0]       r_hi, n_hi;
    logic [bscff_pkg::WORD_AW-1:0]     r_word, n_word;
    logic [bscff_pkg::WORD_AW-1:0]     r_last_w, n_last_w;
    logic [bscff_pkg::WORD_AW-1:0]     r_dword, n_dword;
    logic                              r_found, n_found;
    logic [bscff_pkg::LEN_W-1:0]       r_fpos, n_fpos;
    logic [bscff_pkg::LEN_W-1:0]       r_count, n_count;
    logic                              r_status, n_status;
    logic                              r_o_status, n_o_status;
    logic                              r_o_flag, n_o_flag;
    logic [bscff_pkg::LEN_W-1:0]       r_o_position, n_o_position;
    logic [bscff_pkg::LEN_W-1:0]       r_o_count, n_o_count;

    logic [bscff_pkg::LEN_W-1:0]       len_act;
    logic                              pos_ok;
    logic                              range_ok;
    logic                              ram_we;
    logic [bscff_pkg::WORD_W-1:0]      ram_wdata;
    logic [bscff_pkg::WORD_W-1:0]      ram_rdata;
    logic [bscff_pkg::WORD_W-1:0]      eff_data;
    bscff_pkg::t_word_res              wres;
    logic                              op_flag;

    // store and shared word unit
    bscff_ram #(
        .WIDTH (bscff_pkg::WORD_W),
        .DEPTH (bscff_pkg::N_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_dword),
        .i_wr_data (ram_wdata),
        .i_rd_addr (r_word),
        .o_rd_data (ram_rdata)
    );

    assign eff_data = r_valid[r_dword] ? ram_rdata : '0;

    bscff_word_unit u_word_unit (
        .i_data (eff_data),
        .i_word (r_dword),
        .i_lo   (r_lo),
        .i_hi   (r_hi),
        .o_res  (wres)
    );

    // bounds checks against the active length
    assign len_act  = (r_map_len > bscff_pkg::LEN_MAX) ? bscff_pkg::LEN_MAX : r_map_len;
    assign pos_ok   = (i_bit_pos != '0) && (i_bit_pos <= len_act);
    assign range_ok = (i_bit_pos != '0) && (i_bit_pos_end <= len_act) &&
                      (i_bit_pos < i_bit_pos_end);

    // flag of the finished operation
    always_comb begin
        case (r_op)
            bscff_pkg::OP_TEST,
            bscff_pkg::OP_RANGE,
            bscff_pkg::OP_FIND,
            bscff_pkg::OP_FIND_CLR: op_flag = r_found;
            bscff_pkg::OP_EMPTY:    op_flag = !r_found;
            default:                op_flag = 1'b0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_dv         = 1'b0;
        n_issue      = r_issue;
        n_valid      = r_valid;
        n_op         = r_op;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_word       = r_word;
        n_last_w     = r_last_w;
        n_dword      = r_dword;
        n_found      = r_found;
        n_fpos       = r_fpos;
        n_count      = r_count;
        n_status     = r_status;
        n_o_status   = r_o_status;
        n_o_flag     = r_o_flag;
        n_o_position = r_o_position;
        n_o_count    = r_o_count;
        ram_we       = 1'b0;
        ram_wdata    = eff_data;

        // output register drains
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            bscff_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = bscff_pkg::t_op'(i_op);
                    n_found  = 1'b0;
                    n_fpos   = '0;
                    n_count  = '0;
                    n_status = 1'b0;
                    n_issue  = 1'b1;
                    n_lo     = '0;
                    n_hi     = '0;
                    n_state  = bscff_pkg::S_DONE;
                    case (bscff_pkg::t_op'(i_op))
                        bscff_pkg::OP_SET,
                        bscff_pkg::OP_CLR,
                        bscff_pkg::OP_TEST: begin
                            if (pos_ok) begin
                                n_lo    = i_bit_pos - 1'b1;
                                n_hi    = i_bit_pos - 1'b1;
                                n_state = bscff_pkg::S_SCAN;
                            end else begin
                                n_status = 1'b1;
                            end
                        end
                        bscff_pkg::OP_RANGE: begin
                            if (range_ok) begin
                                n_lo    = i_bit_pos - 1'b1;
                                n_hi    = i_bit_pos_end - 1'b1;
                                n_state = bscff_pkg::S_SCAN;
                            end else begin
                                n_status = 1'b1;
                            end
                        end
                        bscff_pkg::OP_COUNT,
                        bscff_pkg::OP_EMPTY,
                        bscff_pkg::OP_FIND,
                        bscff_pkg::OP_FIND_CLR: begin
                            // zero length: nothing to scan
                            if (len_act != '0) begin
                                n_hi    = len_act - 1'b1;
                                n_state = bscff_pkg::S_SCAN;
                            end
                        end
                        bscff_pkg::OP_CLR_ALL: begin
                            n_valid = '0;
                        end
                        default: begin
                            n_status = 1'b1;
                        end
                    endcase
                    n_word   = bscff_pkg::WORD_AW'(n_lo[bscff_pkg::LEN_W-1:bscff_pkg::BIT_AW]);
                    n_last_w = bscff_pkg::WORD_AW'(n_hi[bscff_pkg::LEN_W-1:bscff_pkg::BIT_AW]);
                end
            end
            bscff_pkg::S_SCAN: begin
                // issue the next word read
                if (r_issue) begin
                    n_dv    = 1'b1;
                    n_dword = r_word;
                    if (r_word == r_last_w) begin
                        n_issue = 1'b0;
                    end else begin
                        n_word = r_word + 1'b1;
                    end
                end
                // examine the word read last cycle
                if (r_dv) begin
                    n_count = r_count + bscff_pkg::LEN_W'(wres.pop);
                    if (wres.any && !r_found) begin
                        n_found = 1'b1;
                        n_fpos  = bscff_pkg::LEN_W'({r_dword, wres.first});
                    end
                    case (r_op)
                        bscff_pkg::OP_SET: begin
                            ram_we  = 1'b1;
                            ram_wdata = eff_data |
                                (bscff_pkg::WORD_W'(1) << r_lo[bscff_pkg::BIT_AW-1:0]);
                            n_valid[r_dword] = 1'b1;
                        end
                        bscff_pkg::OP_CLR: begin
                            ram_we  = 1'b1;
                            ram_wdata = eff_data &
                                ~(bscff_pkg::WORD_W'(1) << r_lo[bscff_pkg::BIT_AW-1:0]);
                            n_valid[r_dword] = 1'b1;
                        end
                        bscff_pkg::OP_FIND_CLR: begin
                            if (wres.any && !r_found) begin
                                ram_we  = 1'b1;
                                ram_wdata = eff_data &
                                    ~(bscff_pkg::WORD_W'(1) << wres.first);
                                n_valid[r_dword] = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    // count scans every word, the others stop at the first hit
                    if ((r_dword == r_last_w) ||
                        (wres.any && (r_op != bscff_pkg::OP_COUNT))) begin
                        n_state = bscff_pkg::S_DONE;
                    end
                end
            end
            bscff_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_o_status   = r_status;
                    n_o_flag     = op_flag && !r_status;
                    n_o_position = '0;
                    n_o_count    = '0;
                    if (((r_op == bscff_pkg::OP_FIND) || (r_op == bscff_pkg::OP_FIND_CLR))
                        && r_found) begin
                        n_o_position = r_fpos + 1'b1;
                    end
                    if (r_op == bscff_pkg::OP_COUNT) begin
                        n_o_count = r_count;
                    end
                    n_state = bscff_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bscff_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bscff_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_dv         <= 1'b0;
            r_issue      <= 1'b0;
            r_valid      <= '0;
            r_map_len    <= bscff_pkg::LEN_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_dv        <= n_dv;
            r_issue     <= n_issue;
            r_valid     <= n_valid;
            if (i_cfg_wr_en) begin
                r_map_len <= i_cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_word       <= n_word;
        r_last_w     <= n_last_w;
        r_dword      <= n_dword;
        r_found      <= n_found;
        r_fpos       <= n_fpos;
        r_count      <= n_count;
        r_status     <= n_status;
        r_o_status   <= n_o_status;
        r_o_flag     <= n_o_flag;
        r_o_position <= n_o_position;
        r_o_count    <= n_o_count;
    end

    assign o_in_stall  = (r_state != bscff_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_flag      = r_o_flag;
    assign o_position  = r_o_position;
    assign o_count     = r_o_count;

`ifndef SYNTH
    // a word under examination never lies beyond the last word of the span
    a_word_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bscff_pkg::S_SCAN) && r_dv |-> (r_dword <= r_last_w))
        else $error("word examined beyond end of span");

    // an error result carries no flag, position or count
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> !o_flag && (o_position == '0) && (o_count == '0))
        else $error("error result with payload");

    // a reported position always comes with a found flag
    a_pos_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_position != '0) |-> o_flag && !o_status)
        else $error("position without flag");

    // clear all has emptied the whole map by the cycle after it is accepted
    a_clr_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bscff_pkg::S_IDLE) && i_in_valid &&
        (i_op == bscff_pkg::OP_CLR_ALL) |=> (r_valid == '0))
        else $error("clear all left valid words");
`endif

endmodule

/* dv/bitmap_set_clear_find_first_checker.sv */
`timescale 1ns / 100ps

module bitmap_set_clear_find_first_checker
    import bscff_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [LEN_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [OP_W-1:0]  i_op,
    input  logic [LEN_W-1:0] i_bit_pos,
    input  logic [LEN_W-1:0] i_bit_pos_end,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic             i_status,
    input  logic             i_flag,
    input  logic [LEN_W-1:0] i_position,
    input  logic [LEN_W-1:0] i_count,
    output int               o_pending,
    output int               o_fail_count
);

    typedef struct packed {
        logic             status;
        logic             flag;
        logic [LEN_W-1:0] position;
        logic [LEN_W-1:0] count;
    } bitmap_reply_t;

    // shadow copy of the map and its length register
    logic [MAX_BITS:1] map_bits = '0;
    logic [LEN_W-1:0]  map_len  = LEN_RESET;
    bitmap_reply_t     pending_replies[$];
    bitmap_reply_t     want_reply;
    bitmap_reply_t     got_reply;
    int                fails = 0;

    // work out the reply of one operation and update the shadow map
    function automatic bitmap_reply_t apply_map_op(input logic [OP_W-1:0] op,
                                                   input logic [LEN_W-1:0] pos,
                                                   input logic [LEN_W-1:0] pos_end);
        bitmap_reply_t r;
        int            eff_len;
        int            first_hit;
        int            set_total;
        logic          pos_ok;
        r         = '0;
        eff_len   = (map_len > LEN_MAX) ? MAX_BITS : int'(map_len);
        pos_ok    = (pos >= 1) && (int'(pos) <= eff_len);
        first_hit = 0;
        set_total = 0;
        // only positions inside the active length are scanned
        for (int p = eff_len; p >= 1; p--) begin
            if (map_bits[p]) begin
                first_hit = p;
                set_total++;
            end
        end
        case (op)
            OP_SET, OP_CLR: begin
                if (pos_ok)
                    map_bits[pos] = (op == OP_SET);
                else
                    r.status = 1'b1;
            end
            OP_TEST: begin
                if (pos_ok)
                    r.flag = map_bits[pos];
                else
                    r.status = 1'b1;
            end
            OP_RANGE: begin
                if (pos == 0 || int'(pos_end) > eff_len || pos >= pos_end) begin
                    r.status = 1'b1;
                end else begin
                    for (int p = pos; p <= pos_end; p++)
                        if (map_bits[p])
                            r.flag = 1'b1;
                end
            end
            OP_COUNT: r.count = LEN_W'(set_total);
            OP_EMPTY: r.flag = (first_hit == 0);
            OP_FIND, OP_FIND_CLR: begin
                r.position = LEN_W'(first_hit);
                if (first_hit != 0) begin
                    r.flag = 1'b1;
                    if (op == OP_FIND_CLR)
                        map_bits[first_hit] = 1'b0;
                end
            end
            OP_CLR_ALL: map_bits = '0;
            default: r.status = 1'b1;
        endcase
        return r;
    endfunction

    function automatic void note_mismatch(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        fails++;
    endfunction

    // follow both channels and the register port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            map_bits = '0;
            map_len  = LEN_RESET;
            pending_replies.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_wr_en)
                map_len = i_cfg_wr_data;

            // result transaction against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                got_reply = {i_status, i_flag, i_position, i_count};
                if (pending_replies.size() == 0) begin
                    $display("%0t: unexpected result, status %0d flag %0d position %0d count %0d",
                             $time, i_status, i_flag, i_position, i_count);
                    fails++;
                end else begin
                    want_reply = pending_replies.pop_front();
                    if (got_reply.status !== want_reply.status)
                        note_mismatch("status", want_reply.status, got_reply.status);
                    if (got_reply.flag !== want_reply.flag)
                        note_mismatch("flag", want_reply.flag, got_reply.flag);
                    if (got_reply.position !== want_reply.position)
                        note_mismatch("position", want_reply.position, got_reply.position);
                    if (got_reply.count !== want_reply.count)
                        note_mismatch("count", want_reply.count, got_reply.count);
                end
            end

            // input transaction
            if (i_in_valid && !i_in_stall)
                pending_replies.push_back(apply_map_op(i_op, i_bit_pos, i_bit_pos_end));

            o_pending <= pending_replies.size();
        end
        o_fail_count <= fails;
    end

endmodule

/* dv/bitmap_set_clear_find_first_core_test.sv */
`timescale 1ns / 100ps

module bitmap_set_clear_find_first_core_test;
    import bscff_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int POS_TOP        = (1 << LEN_W) - 1;
    localparam int PHASE_ITEMS    = 110;

    localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [LEN_W-1:0] i_cfg_wr_data;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [OP_W-1:0]  i_op;
    logic [LEN_W-1:0] i_bit_pos;
    logic [LEN_W-1:0] i_bit_pos_end;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic             o_status;
    logic             o_flag;
    logic [LEN_W-1:0] o_position;
    logic [LEN_W-1:0] o_count;

    int          pending;
    int          fail_count;
    int          burst_left  = 8;
    int          idle_cycles = 0;
    int          stall_left  = 0;
    int          stall_tick  = 0;
    stall_mode_t stall_mode  = STALL_NONE;

    always #CLK_HALF i_clk = ~i_clk;

    bitmap_set_clear_find_first_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_bit_pos     (i_bit_pos),
        .i_bit_pos_end (i_bit_pos_end),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_flag        (o_flag),
        .o_position    (o_position),
        .o_count       (o_count)
    );

    bitmap_set_clear_find_first_checker map_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_bit_pos     (i_bit_pos),
        .i_bit_pos_end (i_bit_pos_end),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_status      (o_status),
        .i_flag        (o_flag),
        .i_position    (o_position),
        .i_count       (o_count),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("bitmap_set_clear_find_first_core_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side stall, switching between patterns
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: i_out_stall <= ((stall_tick % 5) < 2);
            default:        i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // one input transaction, then burst and gap bookkeeping
    task automatic send_item(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] pos,
                             input logic [LEN_W-1:0] pos_end);
        int gap;
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_bit_pos     <= pos;
        i_bit_pos_end <= pos_end;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // hold the sender until every result is back, then let the block settle
    task automatic wait_results(input int settle);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_len(input logic [LEN_W-1:0] len);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= LEN_W'($urandom_range(0, POS_TOP));
    endtask

    // position biased to the low end and the length edges
    function automatic logic [LEN_W-1:0] pick_pos(input int eff);
        int k;
        int hi;
        k  = $urandom_range(0, 99);
        hi = (eff < 1) ? 1 : eff;
        if (k < 4)  return '0;
        if (k < 8)  return LEN_W'($urandom_range(0, POS_TOP));
        if (k < 14) return LEN_W'(eff);
        if (k < 18) return LEN_W'(eff + 1);
        if (k < 55) return LEN_W'($urandom_range(1, (hi < 48) ? hi : 48));
        return LEN_W'($urandom_range(1, hi));
    endfunction

    function automatic logic [OP_W-1:0] OP_OP_UNUSED_PICK();
        return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endfunction

    task automatic random_item(input int eff);
        logic [OP_W-1:0]  op;
        logic [LEN_W-1:0] pos;
        logic [LEN_W-1:0] pos_end;
        int               k;
        k       = $urandom_range(0, 99);
        pos     = LEN_W'($urandom_range(0, POS_TOP));
        pos_end = LEN_W'($urandom_range(0, POS_TOP));
        if (k < 30)      op = OP_SET;
        else if (k < 40) op = OP_CLR;
        else if (k < 50) op = OP_TEST;
        else if (k < 61) op = OP_RANGE;
        else if (k < 67) op = OP_COUNT;
        else if (k < 72) op = OP_EMPTY;
        else if (k < 80) op = OP_FIND;
        else if (k < 93) op = OP_FIND_CLR;
        else if (k < 94) op = OP_CLR_ALL;
        else if (k < 97) op = OP_OP_UNUSED_PICK();
        else             op = OP_W'($urandom_range(0, 15));
        if (op == OP_SET || op == OP_CLR || op == OP_TEST)
            pos = pick_pos(eff);
        if (op == OP_RANGE) begin
            pos = pick_pos(eff);
            k   = $urandom_range(0, 99);
            if (k < 65)      pos_end = LEN_W'(pos + $urandom_range(1, 40));
            else if (k < 75) pos_end = pos;
            else if (k < 85) pos_end = pick_pos(eff);
        end
        send_item(op, pos, pos_end);
    endtask

    // stimulus
    initial begin
        int phase_len[$];
        int eff;
        int n_items;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_op          = OP_SET;
        i_bit_pos     = '0;
        i_bit_pos_end = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: word edges, bad positions and ranges, unused ops
        send_item(OP_SET, 11'd1, 11'd0);
        send_item(OP_SET, 11'd8, 11'd0);
        send_item(OP_SET, 11'd9, 11'd0);
        send_item(OP_SET, 11'd1024, 11'd0);
        send_item(OP_SET, 11'd0, 11'd0);
        send_item(OP_CLR, 11'd2047, 11'd0);
        send_item(OP_TEST, 11'd1025, 11'd0);
        send_item(OP_TEST, 11'd1, 11'd0);
        send_item(OP_TEST, 11'd2, 11'd0);
        send_item(OP_RANGE, 11'd2, 11'd8);
        send_item(OP_RANGE, 11'd2, 11'd7);
        send_item(OP_RANGE, 11'd0, 11'd5);
        send_item(OP_RANGE, 11'd9, 11'd9);
        send_item(OP_RANGE, 11'd10, 11'd2047);
        send_item(OP_RANGE, 11'd1023, 11'd1024);
        send_item(OP_COUNT, 11'd0, 11'd0);
        send_item(OP_FIND, 11'd0, 11'd0);
        send_item(OP_FIND_CLR, 11'd0, 11'd0);
        send_item(OP_FIND_CLR, 11'd0, 11'd0);
        send_item(OP_EMPTY, 11'd0, 11'd0);
        send_item(OP_UNUSED_LO, 11'd5, 11'd6);
        send_item(OP_UNUSED_HI, 11'd2047, 11'd2047);
        send_item(OP_CLR, 11'd1024, 11'd0);
        send_item(OP_CLR_ALL, 11'd0, 11'd0);
        send_item(OP_EMPTY, 11'd0, 11'd0);
        send_item(OP_FIND, 11'd0, 11'd0);
        wait_results(DRAIN_CYCLES);

        // random phases over several lengths, extremes included
        phase_len = '{0, 1, 2047, 64, 65, 1023, 8, 130, 1024};
        phase_len.push_back($urandom_range(2, 1024));
        phase_len.push_back($urandom_range(1, POS_TOP));
        foreach (phase_len[i]) begin
            write_len(LEN_W'(phase_len[i]));
            eff     = (phase_len[i] > MAX_BITS) ? MAX_BITS : phase_len[i];
            n_items = (phase_len[i] == 0) ? 30 : PHASE_ITEMS;
            for (int j = 0; j < n_items; j++) begin
                random_item(eff);
                if ($urandom_range(0, 199) == 0)
                    wait_results(0);
            end
            wait_results(DRAIN_CYCLES);
        end

        if (fail_count == 0 && pending == 0)
            $display("bitmap_set_clear_find_first_core_test passed");
        else
            $display("bitmap_set_clear_find_first_core_test failed");
        $finish;
    end

endmodule
